[design/nta_pkg.sv]
// Shared types, constants and arithmetic helpers for the normal texel strength adjuster.
package nta_pkg;

    typedef logic signed [15:0] q15_t;

    // Configuration register indexes.
    localparam logic CFG_STRENGTH = 1'b0;
    localparam logic CFG_FLIP     = 1'b1;

    localparam logic [15:0] STRENGTH_RESET = 16'd8192;
    localparam logic [15:0] STRENGTH_MAX   = 16'd32768;
    localparam q15_t        Q15_MAX        = 16'sd32767;
    localparam q15_t        Q15_MIN        = -16'sd32768;

    // One in Q2.30.
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    // Reciprocal of 255 scaled by 2^31, rounded up.
    localparam logic [47:0] RECIP_255 = 48'd8421505;
    // Squared-length floor for the fallback normal (1e-8 in Q56).
    localparam logic [61:0] LEN2_TOL = 62'd720575941;
    // The same floor on the unscaled sum of Q1.15 squares.
    localparam logic [31:0] SUM_TOL = 32'd11;

    // Decode a texel byte into Q1.15, round half away from zero, saturated.
    function automatic q15_t decode_byte(input logic [7:0] c);
        logic signed [9:0] d;
        logic [7:0]        ad;
        logic [47:0]       t;
        logic [47:0]       p;
        logic [16:0]       q;
        d  = $signed({1'b0, c, 1'b0}) - 10'sd255;
        ad = d[9] ? 8'(-d) : 8'(d);
        t  = {25'd0, ad, 15'd0} + 48'd127;
        p  = t * RECIP_255;
        q  = p[47:31];
        if (d[9])
            decode_byte = 16'(-$signed({1'b0, q}));
        else if (q > 17'd32767)
            decode_byte = Q15_MAX;
        else
            decode_byte = q15_t'(q[15:0]);
    endfunction

    // Negate a Q1.15 value with saturation.
    function automatic q15_t neg_sat(input q15_t v);
        if (v == Q15_MIN)
            neg_sat = Q15_MAX;
        else
            neg_sat = -v;
    endfunction

    // Attach a sign to a quotient magnitude; positive results saturate to Q1.15.
    function automatic q15_t apply_sign(input logic neg, input logic [15:0] q);
        if (neg)
            apply_sign = 16'(-$signed({1'b0, q}));
        else if (q > 16'd32767)
            apply_sign = Q15_MAX;
        else
            apply_sign = q15_t'(q);
    endfunction

    // Magnitude of a Q1.15 value.
    function automatic logic [15:0] mag15(input q15_t v);
        mag15 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    // Encode a Q1.15 component into a rounded byte.
    function automatic logic [7:0] encode_q15(input q15_t n);
        logic [23:0] t;
        logic [23:0] e;
        t = {8'd0, ~n[15], n[14:0]};
        e = t * 24'd255 + 24'd32768;
        encode_q15 = e[23:16];
    endfunction

endpackage

[design/nta_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with remainder.
module nta_isqrt #(
    parameter int W  = 32,
    parameter int PW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [W-1:0]     in_rad,
    input  logic [PW-1:0]    in_pay,
    output logic             out_valid,
    output logic [W/2-1:0]   out_root,
    output logic [W/2:0]     out_rem,
    output logic [PW-1:0]    out_pay
);

    localparam int N = W / 2;

    logic [W-1:0]  v_reg   [N];
    logic [W-1:0]  res_reg [N];
    logic [PW-1:0] pay_reg [N];
    logic          vld_reg [N];

    genvar k;
    for (k = 0; k < N; k++) begin : g_stage
        localparam logic [W-1:0] BITC = W'(1) << (W - 2 - 2 * k);

        logic [W-1:0]  v_in;
        logic [W-1:0]  res_in;
        logic [PW-1:0] pay_in;
        logic          vld_in;
        logic [W-1:0]  trial;
        logic [W-1:0]  v_next;
        logic [W-1:0]  res_next;

        if (k == 0) begin : g_first
            assign v_in   = in_rad;
            assign res_in = '0;
            assign pay_in = in_pay;
            assign vld_in = in_valid;
        end
        else begin : g_next
            assign v_in   = v_reg[k-1];
            assign res_in = res_reg[k-1];
            assign pay_in = pay_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // One digit of the restoring square root.
        always_comb
        begin
            trial = res_in + BITC;
            if (v_in >= trial)
            begin
                v_next   = v_in - trial;
                res_next = (res_in >> 1) + BITC;
            end
            else
            begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[k]   <= v_next;
                res_reg[k] <= res_next;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = res_reg[N-1][N-1:0];
    assign out_rem   = v_reg[N-1][N:0];
    assign out_pay   = pay_reg[N-1];

endmodule

[design/nta_div3.sv]
// Pipelined restoring divider, three numerators over one shared divisor, one bit per stage.
module nta_div3 #(
    parameter int DW = 29,
    parameter int QW = 16,
    parameter int PW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [DW-1:0]       in_den,
    input  logic [DW+QW-1:0]    in_num [3],
    input  logic [PW-1:0]       in_pay,
    output logic                out_valid,
    output logic [QW-1:0]       out_quo [3],
    output logic [PW-1:0]       out_pay
);

    localparam int CW = DW + QW;

    logic [CW-1:0] rem_reg [QW][3];
    logic [QW-1:0] quo_reg [QW][3];
    logic [DW-1:0] den_reg [QW];
    logic [PW-1:0] pay_reg [QW];
    logic          vld_reg [QW];

    genvar k, j;
    for (k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;

        logic [CW-1:0] rem_in [3];
        logic [QW-1:0] quo_in [3];
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;
        logic          vld_in;
        logic [CW-1:0] dsh;

        if (k == 0) begin : g_first
            assign rem_in = in_num;
            assign quo_in = '{default: '0};
            assign den_in = in_den;
            assign pay_in = in_pay;
            assign vld_in = in_valid;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign pay_in = pay_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign dsh = CW'(den_in) << SH;

        // Trial subtraction in every lane.
        for (j = 0; j < 3; j++) begin : g_lane
            logic [CW-1:0] rem_next;
            logic [QW-1:0] quo_next;

            always_comb
            begin
                if (rem_in[j] >= dsh)
                begin
                    rem_next = rem_in[j] - dsh;
                    quo_next = {quo_in[j][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_in[j];
                    quo_next = {quo_in[j][QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k][j] <= rem_next;
                    quo_reg[k][j] <= quo_next;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k] <= den_in;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

[design/normal_texel_strength_adjust.sv]
// Top level of the normal texel strength adjuster: decode, Z rebuild, two normalizations, encode.
//
// Takes one RGB normal-map texel per cycle unless the output is stalled, and returns one adjusted
// texel per word, in order. The pipeline depth is set by the three bit-serial square root
// pipelines (16, 29 and 31 stages) and the two 16-stage divider pipelines. A new word is
// accepted in every cycle in which the output register is empty or being drained; when the
// output is stalled the whole pipeline holds. Strength and flip_green must be written while the
// pipeline is empty.
module normal_texel_strength_adjust (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // texel_red, texel_green, texel_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import nta_pkg::*;

    logic        adv;
    logic [15:0] strength_reg;
    logic        flip_reg;
    logic [15:0] strength_sat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= STRENGTH_RESET;
            flip_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STRENGTH: strength_reg <= cfg_data;
                CFG_FLIP:     flip_reg     <= cfg_data[0];
                default:      flip_reg     <= flip_reg;
            endcase
        end
    end

    assign strength_sat = (strength_reg > STRENGTH_MAX) ? STRENGTH_MAX : strength_reg;

    // The whole pipeline moves when the output register can take a word.
    logic        out_vld_reg;
    logic [23:0] out_data_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: decode bytes and apply the green convention.
    logic s1_vld_reg;
    q15_t s1_x_reg, s1_y_reg, s1_z_reg;
    q15_t y_dec;

    assign y_dec = decode_byte(s_axis_tdata[15:8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg <= decode_byte(s_axis_tdata[7:0]);
            s1_y_reg <= flip_reg ? y_dec : neg_sat(y_dec);
            s1_z_reg <= decode_byte(s_axis_tdata[23:16]);
        end
    end

    // Stage 2: squares of X and Y for the Z rebuild.
    logic        s2_vld_reg;
    logic [30:0] s2_xx_reg, s2_yy_reg;
    q15_t        s2_x_reg, s2_y_reg, s2_z_reg;
    logic [31:0] xx_full, yy_full;

    assign xx_full = 32'(s1_x_reg) * 32'(s1_x_reg);
    assign yy_full = 32'(s1_y_reg) * 32'(s1_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_xx_reg <= xx_full[30:0];
            s2_yy_reg <= yy_full[30:0];
            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_z_reg  <= s1_z_reg;
        end
    end

    // Stage 3: radicand 1 - min(x^2 + y^2, 1) in Q2.30.
    logic        s3_vld_reg;
    logic [31:0] s3_rad_reg;
    q15_t        s3_x_reg, s3_y_reg, s3_z_reg;
    logic        s3_rebuild_reg;
    logic [31:0] xy2, xy2_cap;

    assign xy2     = 32'(s2_xx_reg) + 32'(s2_yy_reg);
    assign xy2_cap = (xy2 > ONE_Q30) ? ONE_Q30 : xy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_rad_reg     <= ONE_Q30 - xy2_cap;
            s3_x_reg       <= s2_x_reg;
            s3_y_reg       <= s2_y_reg;
            s3_z_reg       <= s2_z_reg;
            s3_rebuild_reg <= (s2_z_reg <= 16'sd0);
        end
    end

    // Square root for the rebuilt Z.
    logic        zr_vld;
    logic [15:0] zr_root;
    logic [16:0] zr_rem;
    logic [48:0] zr_pay;

    nta_isqrt #(.W(32), .PW(49)) u_zroot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_vld_reg),
        .in_rad    (s3_rad_reg),
        .in_pay    ({s3_rebuild_reg, s3_x_reg, s3_y_reg, s3_z_reg}),
        .out_valid (zr_vld),
        .out_root  (zr_root),
        .out_rem   (zr_rem),
        .out_pay   (zr_pay)
    );

    // Stage 4: round the root to nearest and pick the Z source.
    logic        s4_vld_reg;
    q15_t        s4_x_reg, s4_y_reg, s4_z_reg;
    logic [16:0] zr_round;
    q15_t        z_sel;

    always_comb
    begin
        zr_round = {1'b0, zr_root} + ((zr_rem > {1'b0, zr_root}) ? 17'd1 : 17'd0);
        if (!zr_pay[48])
            z_sel = q15_t'(zr_pay[15:0]);
        else if (zr_round > 17'd32767)
            z_sel = Q15_MAX;
        else
            z_sel = q15_t'(zr_round[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= zr_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_x_reg <= q15_t'(zr_pay[47:32]);
            s4_y_reg <= q15_t'(zr_pay[31:16]);
            s4_z_reg <= z_sel;
        end
    end

    // Stage 5: squares for the first length.
    logic        s5_vld_reg;
    logic [30:0] s5_sq_reg [3];
    q15_t        s5_v_reg  [3];
    logic [31:0] sq5_full  [3];

    assign sq5_full[0] = 32'(s4_x_reg) * 32'(s4_x_reg);
    assign sq5_full[1] = 32'(s4_y_reg) * 32'(s4_y_reg);
    assign sq5_full[2] = 32'(s4_z_reg) * 32'(s4_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_sq_reg[0] <= sq5_full[0][30:0];
            s5_sq_reg[1] <= sq5_full[1][30:0];
            s5_sq_reg[2] <= sq5_full[2][30:0];
            s5_v_reg[0]  <= s4_x_reg;
            s5_v_reg[1]  <= s4_y_reg;
            s5_v_reg[2]  <= s4_z_reg;
        end
    end

    // Stage 6: sum of squares and the near-zero test.
    logic        s6_vld_reg;
    logic [31:0] s6_sum_reg;
    q15_t        s6_v_reg [3];
    logic        s6_zero_reg;
    logic [31:0] sum6;

    assign sum6 = 32'(s5_sq_reg[0]) + 32'(s5_sq_reg[1]) + 32'(s5_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (adv)
            s6_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_sum_reg  <= sum6;
            s6_zero_reg <= (sum6 < SUM_TOL);
            s6_v_reg    <= s5_v_reg;
        end
    end

    // First length: square root of the Q56 squared length.
    logic        l1_vld;
    logic [28:0] l1_root;
    logic [29:0] l1_rem;
    logic [48:0] l1_pay;

    nta_isqrt #(.W(58), .PW(49)) u_len1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s6_vld_reg),
        .in_rad    ({s6_sum_reg[31:0], 26'd0}),
        .in_pay    ({s6_zero_reg, s6_v_reg[0], s6_v_reg[1], s6_v_reg[2]}),
        .out_valid (l1_vld),
        .out_root  (l1_root),
        .out_rem   (l1_rem),
        .out_pay   (l1_pay)
    );

    // Stage 7: rounded numerators for the first normalization.
    logic        s7_vld_reg;
    logic [28:0] s7_den_reg;
    logic [44:0] s7_num_reg [3];
    logic [3:0]  s7_pay_reg;
    q15_t        l1_v [3];

    assign l1_v[0] = q15_t'(l1_pay[47:32]);
    assign l1_v[1] = q15_t'(l1_pay[31:16]);
    assign l1_v[2] = q15_t'(l1_pay[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else if (adv)
            s7_vld_reg <= l1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_num_reg[i] <= (45'(mag15(l1_v[i])) << 28) + 45'(l1_root >> 1);
            end
            s7_den_reg <= l1_root;
            s7_pay_reg <= {l1_pay[48], l1_v[0][15], l1_v[1][15], l1_v[2][15]};
        end
    end

    logic        d1_vld;
    logic [15:0] d1_quo [3];
    logic [3:0]  d1_pay;

    nta_div3 #(.DW(29), .QW(16), .PW(4)) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s7_vld_reg),
        .in_den    (s7_den_reg),
        .in_num    (s7_num_reg),
        .in_pay    (s7_pay_reg),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_pay   (d1_pay)
    );

    // Stage 8: signed unit vector, or the fallback normal.
    logic s8_vld_reg;
    q15_t s8_n_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_vld_reg <= 1'b0;
        else if (adv)
            s8_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d1_pay[3])
            begin
                s8_n_reg[0] <= '0;
                s8_n_reg[1] <= '0;
                s8_n_reg[2] <= Q15_MAX;
            end
            else
            begin
                s8_n_reg[0] <= apply_sign(d1_pay[2], d1_quo[0]);
                s8_n_reg[1] <= apply_sign(d1_pay[1], d1_quo[1]);
                s8_n_reg[2] <= apply_sign(d1_pay[0], d1_quo[2]);
            end
        end
    end

    // Stage 9: scale X and Y by strength, widen Z to Q28.
    logic        s9_vld_reg;
    logic [30:0] s9_a_reg [3];
    logic [2:0]  s9_neg_reg;
    logic [31:0] ax_full, ay_full;

    assign ax_full = 32'(mag15(s8_n_reg[0])) * 32'(strength_sat);
    assign ay_full = 32'(mag15(s8_n_reg[1])) * 32'(strength_sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_vld_reg <= 1'b0;
        else if (adv)
            s9_vld_reg <= s8_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_a_reg[0] <= ax_full[30:0];
            s9_a_reg[1] <= ay_full[30:0];
            s9_a_reg[2] <= 31'(mag15(s8_n_reg[2])) << 13;
            s9_neg_reg  <= {s8_n_reg[0][15], s8_n_reg[1][15], s8_n_reg[2][15]};
        end
    end

    // Stage 10: squares for the second length.
    logic        s10_vld_reg;
    logic [60:0] s10_sq_reg [3];
    logic [30:0] s10_a_reg  [3];
    logic [2:0]  s10_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_vld_reg <= 1'b0;
        else if (adv)
            s10_vld_reg <= s9_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s10_sq_reg[i] <= 61'(s9_a_reg[i]) * 61'(s9_a_reg[i]);
            end
            s10_a_reg   <= s9_a_reg;
            s10_neg_reg <= s9_neg_reg;
        end
    end

    // Stage 11: second squared length and its near-zero test.
    logic        s11_vld_reg;
    logic [61:0] s11_len2_reg;
    logic [30:0] s11_a_reg [3];
    logic [2:0]  s11_neg_reg;
    logic        s11_zero_reg;
    logic [61:0] len2;

    assign len2 = 62'(s10_sq_reg[0]) + 62'(s10_sq_reg[1]) + 62'(s10_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s11_vld_reg <= 1'b0;
        else if (adv)
            s11_vld_reg <= s10_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s11_len2_reg <= len2;
            s11_zero_reg <= (len2 < LEN2_TOL);
            s11_a_reg    <= s10_a_reg;
            s11_neg_reg  <= s10_neg_reg;
        end
    end

    logic        l2_vld;
    logic [30:0] l2_root;
    logic [31:0] l2_rem;
    logic [96:0] l2_pay;

    nta_isqrt #(.W(62), .PW(97)) u_len2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s11_vld_reg),
        .in_rad    (s11_len2_reg),
        .in_pay    ({s11_zero_reg, s11_neg_reg, s11_a_reg[0], s11_a_reg[1], s11_a_reg[2]}),
        .out_valid (l2_vld),
        .out_root  (l2_root),
        .out_rem   (l2_rem),
        .out_pay   (l2_pay)
    );

    // Stage 12: rounded numerators for the second normalization.
    logic        s12_vld_reg;
    logic [30:0] s12_den_reg;
    logic [46:0] s12_num_reg [3];
    logic [3:0]  s12_pay_reg;
    logic [30:0] l2_a [3];

    assign l2_a[0] = l2_pay[92:62];
    assign l2_a[1] = l2_pay[61:31];
    assign l2_a[2] = l2_pay[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s12_vld_reg <= 1'b0;
        else if (adv)
            s12_vld_reg <= l2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s12_num_reg[i] <= (47'(l2_a[i]) << 15) + 47'(l2_root >> 1);
            end
            s12_den_reg <= l2_root;
            s12_pay_reg <= l2_pay[96:93];
        end
    end

    logic        d2_vld;
    logic [15:0] d2_quo [3];
    logic [3:0]  d2_pay;

    nta_div3 #(.DW(31), .QW(16), .PW(4)) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s12_vld_reg),
        .in_den    (s12_den_reg),
        .in_num    (s12_num_reg),
        .in_pay    (s12_pay_reg),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_pay   (d2_pay)
    );

    // Stage 13: final unit vector encoded into the output register.
    q15_t n_fin [3];

    always_comb
    begin
        if (d2_pay[3])
        begin
            n_fin[0] = '0;
            n_fin[1] = '0;
            n_fin[2] = Q15_MAX;
        end
        else
        begin
            n_fin[0] = apply_sign(d2_pay[2], d2_quo[0]);
            n_fin[1] = apply_sign(d2_pay[1], d2_quo[1]);
            n_fin[2] = apply_sign(d2_pay[0], d2_quo[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= {encode_q15(n_fin[2]), encode_q15(n_fin[1]), encode_q15(n_fin[0])};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
